>>> hw/rtl/pica_pkg.sv
// Shared types and constants of the anti-windup PI controller.
// Used by pica_cfg, pica_ctrl, pica_dp and pi_controller_antiwindup; no dependencies.
package pica_pkg;

  localparam int DATA_WIDTH_DEF = 32;   // width of the controller state words
  localparam int WIDE_BITS      = 48;   // width of the accumulator and of the scaled products
  localparam int GAIN_W         = 31;
  localparam int LIMIT_W        = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int STATUS_W       = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIM  = 2'd3;

  // limit status codes
  localparam logic [STATUS_W-1:0] STAT_WITHIN = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UPPER  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_LOWER  = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ERR,
    OP_SUM,
    OP_MAG,
    OP_MLO,
    OP_MHI,
    OP_SCALE,
    OP_INNER,
    OP_RAW,
    OP_CLAMP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic use_kp;   // gain select for the multiply steps
  } cmd_t;

  typedef struct packed {
    logic        [GAIN_W-1:0]  kp;
    logic        [GAIN_W-1:0]  ki;
    logic signed [LIMIT_W-1:0] upper;
    logic signed [LIMIT_W-1:0] lower;
  } cfg_t;

endpackage

>>> hw/rtl/pica_cfg.sv
// Configuration register bank: gains and output limits.
// Depends on pica_pkg.
module pica_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pica_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pica_pkg::LIMIT_W-1:0]        cfg_wdata_i,
  output pica_pkg::cfg_t                      cfg_o
);

  pica_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= '0;
      cfg_q.ki    <= '0;
      cfg_q.upper <= {1'b0, {(pica_pkg::LIMIT_W-1){1'b1}}};
      cfg_q.lower <= {1'b1, {(pica_pkg::LIMIT_W-1){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pica_pkg::REG_PROP_GAIN:  cfg_q.kp    <= cfg_wdata_i[pica_pkg::GAIN_W-1:0];
        pica_pkg::REG_INTEG_GAIN: cfg_q.ki    <= cfg_wdata_i[pica_pkg::GAIN_W-1:0];
        pica_pkg::REG_UPPER_LIM:  cfg_q.upper <= cfg_wdata_i;
        pica_pkg::REG_LOWER_LIM:  cfg_q.lower <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/pica_ctrl.sv
// Sequencer of the PI controller: steps the datapath through one item.
// Depends on pica_pkg.
module pica_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_stall_i,
  output pica_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_SUM,
    S_MAG_I,
    S_MLO_I,
    S_MHI_I,
    S_SCL_I,
    S_INNER,
    S_MAG_P,
    S_MLO_P,
    S_MHI_P,
    S_SCL_P,
    S_RAW,
    S_CLAMP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: pica_pkg::OP_NOP, use_kp: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = pica_pkg::OP_LOAD;
          state_d  = S_ERR;
        end
      end
      S_ERR:   begin cmd_o.op = pica_pkg::OP_ERR;   state_d = S_SUM;   end
      S_SUM:   begin cmd_o.op = pica_pkg::OP_SUM;   state_d = S_MAG_I; end
      S_MAG_I: begin cmd_o.op = pica_pkg::OP_MAG;   state_d = S_MLO_I; end
      S_MLO_I: begin cmd_o.op = pica_pkg::OP_MLO;   state_d = S_MHI_I; end
      S_MHI_I: begin cmd_o.op = pica_pkg::OP_MHI;   state_d = S_SCL_I; end
      S_SCL_I: begin cmd_o.op = pica_pkg::OP_SCALE; state_d = S_INNER; end
      S_INNER: begin cmd_o.op = pica_pkg::OP_INNER; state_d = S_MAG_P; end
      S_MAG_P: begin cmd_o.op = pica_pkg::OP_MAG;   state_d = S_MLO_P; end
      S_MLO_P: begin
        cmd_o = '{op: pica_pkg::OP_MLO, use_kp: 1'b1};
        state_d = S_MHI_P;
      end
      S_MHI_P: begin
        cmd_o = '{op: pica_pkg::OP_MHI, use_kp: 1'b1};
        state_d = S_SCL_P;
      end
      S_SCL_P: begin cmd_o.op = pica_pkg::OP_SCALE; state_d = S_RAW;   end
      S_RAW:   begin cmd_o.op = pica_pkg::OP_RAW;   state_d = S_CLAMP; end
      S_CLAMP: begin
        // wait here while the previous result still sits unread
        if (!out_stall_i) begin
          cmd_o.op = pica_pkg::OP_CLAMP;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> hw/rtl/pica_dp.sv
// Datapath of the PI controller: error, shared gain multiplier, clamp, state and result register.
// Depends on pica_pkg; driven by pica_ctrl commands.
module pica_dp #(
  parameter int DATA_WIDTH = pica_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pica_pkg::cmd_t                      cmd_i,
  input  pica_pkg::cfg_t                      cfg_i,
  input  logic signed [31:0]                  setpoint_i,
  input  logic signed [31:0]                  measurement_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_stall_o,
  output logic signed [31:0]                  drive_output_o,
  output logic [pica_pkg::STATUS_W-1:0]       limit_status_o
);

  localparam int WW  = 64;
  localparam int WB  = pica_pkg::WIDE_BITS;
  localparam int GW  = pica_pkg::GAIN_W;
  localparam int MW  = WB - 1;          // product operand magnitude
  localparam int LOW = 16;              // Q16.16 fraction bits
  localparam int HW  = MW - LOW;
  localparam int PLW = LOW + GW;
  localparam int PHW = HW + GW;
  localparam int RW  = PHW + 1;

  typedef logic signed [WW-1:0] wide_t;

  localparam wide_t DW_MAX = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
  localparam wide_t DW_MIN = -DW_MAX - wide_t'(1);
  localparam wide_t WB_MAX = (wide_t'(1) <<< (WB - 1)) - wide_t'(1);
  localparam wide_t WB_MIN = -WB_MAX - wide_t'(1);
  localparam logic [RW-1:0] MAG_LIM = (RW'(1) << (WB - 1)) - RW'(1);
  localparam logic [WB:0]   RND     = (WB + 1)'(1) << (LOW - 1);

  function automatic wide_t sat_dw(wide_t v);
    wide_t r;
    r = v;
    if (v > DW_MAX) r = DW_MAX;
    if (v < DW_MIN) r = DW_MIN;
    return r;
  endfunction

  function automatic wide_t sat_wb(wide_t v);
    wide_t r;
    r = v;
    if (v > WB_MAX) r = WB_MAX;
    if (v < WB_MIN) r = WB_MIN;
    return r;
  endfunction

  // item registers
  logic signed [31:0]           sp_q, ms_q;
  logic signed [DATA_WIDTH-1:0] e_q, raw_q;
  logic signed [DATA_WIDTH:0]   de_q;
  logic signed [WB-1:0]         acc_q;
  logic [MW-1:0]                mag_q;
  logic                         neg_q;
  logic [PLW-1:0]               plo_q;
  logic [PHW-1:0]               phi_q;
  // controller state
  logic signed [DATA_WIDTH-1:0] pe_q, pr_q, re_q, oe_q;
  // result register
  logic                         ovalid_q;
  logic signed [31:0]           drive_q;
  logic [pica_pkg::STATUS_W-1:0] status_q;

  wide_t e_w, pe_w, pr_w, re_w, oe_w, de_w, acc_w, raw_w, up_w, lo_w;
  wide_t diff_w, sum_w, inner_w, rawsum_w;
  logic [GW-1:0]  gain;
  logic [WB-1:0]  abs_v;
  logic [MW-1:0]  mag_d;
  logic [HW-1:0]  mul_a;
  logic [PHW-1:0] mul_p;
  logic [RW-1:0]  r_v;
  logic [WB-1:0]  r_lo;
  logic signed [WB-1:0] scaled_d;
  logic                 take_result;
  wide_t                excess_w;
  logic signed [31:0]   drive_d;
  logic [pica_pkg::STATUS_W-1:0] status_d;

  always_comb begin
    e_w   = wide_t'(e_q);
    pe_w  = wide_t'(pe_q);
    pr_w  = wide_t'(pr_q);
    re_w  = wide_t'(re_q);
    oe_w  = wide_t'(oe_q);
    de_w  = wide_t'(de_q);
    acc_w = wide_t'(acc_q);
    raw_w = wide_t'(raw_q);
    up_w  = wide_t'(cfg_i.upper);
    lo_w  = wide_t'(cfg_i.lower);

    diff_w   = wide_t'(sp_q) - wide_t'(ms_q);
    sum_w    = e_w + pe_w - re_w - oe_w;
    inner_w  = de_w + acc_w;
    rawsum_w = pr_w + acc_w;

    gain = cmd_i.use_kp ? cfg_i.kp : cfg_i.ki;

    // magnitude of the multiplier operand, limited to 2^47-1
    abs_v = acc_q[WB-1] ? (~acc_q + WB'(1)) : acc_q;
    mag_d = abs_v[WB-1] ? {MW{1'b1}} : abs_v[MW-1:0];

    // one multiplier serves both partial products of both gains
    mul_a = (cmd_i.op == pica_pkg::OP_MHI) ? mag_q[MW-1:LOW] : HW'(mag_q[LOW-1:0]);
    mul_p = PHW'(mul_a) * PHW'(gain);

    // recombine partial products with round to nearest, then saturate with sign
    r_v = RW'(phi_q) + RW'((WB + 1)'((WB + 1)'(plo_q) + RND) >> LOW);
    if (neg_q) begin
      if (r_v > MAG_LIM) r_lo = {1'b1, {(WB-1){1'b0}}};
      else               r_lo = ~r_v[WB-1:0] + WB'(1);
    end else begin
      if (r_v > MAG_LIM) r_lo = MAG_LIM[WB-1:0];
      else               r_lo = r_v[WB-1:0];
    end
    scaled_d = r_lo;

    // clamp; the upper test has priority when the limits are inverted
    if (raw_w > up_w) begin
      excess_w = sat_dw(raw_w - up_w);
      drive_d  = cfg_i.upper;
      status_d = pica_pkg::STAT_UPPER;
    end else if (raw_w < lo_w) begin
      excess_w = sat_dw(raw_w - lo_w);
      drive_d  = cfg_i.lower;
      status_d = pica_pkg::STAT_LOWER;
    end else begin
      excess_w = '0;
      drive_d  = raw_w[31:0];
      status_d = pica_pkg::STAT_WITHIN;
    end
  end

  assign out_stall_o = ovalid_q && !out_ready_i;
  assign take_result = (cmd_i.op == pica_pkg::OP_CLAMP);

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pica_pkg::OP_LOAD: begin
        sp_q <= setpoint_i;
        ms_q <= measurement_i;
      end
      pica_pkg::OP_ERR: e_q <= DATA_WIDTH'(sat_dw(diff_w));
      pica_pkg::OP_SUM: begin
        acc_q <= WB'(sat_wb(sum_w));
        de_q  <= (DATA_WIDTH + 1)'(e_w - pe_w);
      end
      pica_pkg::OP_MAG: begin
        mag_q <= mag_d;
        neg_q <= acc_q[WB-1];
      end
      pica_pkg::OP_MLO:   plo_q <= mul_p[PLW-1:0];
      pica_pkg::OP_MHI:   phi_q <= mul_p;
      pica_pkg::OP_SCALE: acc_q <= scaled_d;
      pica_pkg::OP_INNER: acc_q <= WB'(sat_wb(inner_w));
      pica_pkg::OP_RAW:   raw_q <= DATA_WIDTH'(sat_dw(rawsum_w));
      default: ;
    endcase
  end

  // controller state carried from item to item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q <= '0;
      pr_q <= '0;
      re_q <= '0;
      oe_q <= '0;
    end else if (take_result) begin
      oe_q <= re_q;
      pe_q <= e_q;
      pr_q <= raw_q;
      re_q <= excess_w[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (take_result) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_result) begin
      drive_q  <= drive_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign drive_output_o = drive_q;
  assign limit_status_o = status_q;

endmodule

>>> hw/rtl/pi_controller_antiwindup.sv
// Incremental PI controller with trapezoidal integration and back-calculation anti-windup.
// Top level; depends on pica_pkg, pica_cfg, pica_ctrl and pica_dp.
//
// Usage:
//   Input stream (s_axis_*): one item is a setpoint/measurement pair, signed Q16.16.
//   Output stream (m_axis_*): one item per input, the clamped drive value and a limit status
//   (within limits, clamped at upper, clamped at lower).
//   Config port: write gains and limits with cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// Sequencing:
//   The sequencer steps one shared 31x31 multiplier through two partial products for each
//   of the two gain multiplications, plus the error, sum, magnitude, scale, add and clamp
//   steps; the next input is taken only once it is back in idle after the clamp step.
// Reset:
//   Gains go to zero, limits to the full 32-bit range, controller state to zero and the
//   output stream to empty.
// Backpressure:
//   The result register holds a finished item until m_axis_tready; the next item is
//   already accepted and computed meanwhile and waits in its final clamp step.
module pi_controller_antiwindup #(
  parameter int DATA_WIDTH = pica_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // setpoint[31:0], measurement[63:32]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // drive_output[31:0],
                                                        // limit_status[33:32], zero pad
  input  logic                           cfg_we_i,
  input  logic [pica_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pica_pkg::LIMIT_W-1:0]   cfg_wdata_i
);

  pica_pkg::cfg_t cfg;
  pica_pkg::cmd_t cmd;
  logic           out_stall;
  logic signed [31:0] drive_output;
  logic [pica_pkg::STATUS_W-1:0] limit_status;

  pica_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pica_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_stall_i (out_stall),
    .cmd_o       (cmd)
  );

  pica_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .setpoint_i     (s_axis_tdata[31:0]),
    .measurement_i  (s_axis_tdata[63:32]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_stall_o    (out_stall),
    .drive_output_o (drive_output),
    .limit_status_o (limit_status)
  );

  assign m_axis_tdata = {6'b0, limit_status, drive_output};

endmodule
